@@ hw/rtl/ffba_pkg.sv @@
// Package for the first-fit block allocator.
// Holds the beat payload types, status codes, controller states and defaults.
// No dependencies.
`default_nettype none

package ffba_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF   = 32;
    localparam logic [31:0] RESET_CAPACITY = 32'd1048576;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [31:0] req_size;
        logic [31:0] block_offset_in;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] granted_offset;
        logic [31:0] granted_tag;
        logic [31:0] free_total;
    } t_rsp;

    typedef enum logic [3:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_SCAN_RD,
        FSM_SCAN_EX,
        FSM_SHIFT_RD,
        FSM_SHIFT_EX,
        FSM_SPLIT_WR,
        FSM_GRANT_WR,
        FSM_MERGE_RD,
        FSM_MERGE_EX,
        FSM_MERGE_WR,
        FSM_DONE
    } t_fsm;

endpackage

`default_nettype wire

@@ hw/rtl/ffba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_block_allocator_unit.sv @@
// First-fit block allocator: a sequencer that keeps the block table in one RAM.
// Depends on ffba_pkg and ffba_ram.
//
// The region is an ordered table of blocks in a single RAM with registered read;
// every table step is a read state followed by a modify/write state. A request
// scans entries until one matches, an allocate that splits a block first shifts
// the later entries up by one, and a free is followed by a coalescing sweep over
// every table entry. Zero-size requests skip the scan. After reset or a capacity
// write the block writes the first entry in its INIT state before it takes
// requests. A result sits in an output register, so the next request is accepted
// while it waits.
`default_nettype none

module first_fit_block_allocator_unit #(
    parameter int MAX_ENTRIES = ffba_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = ffba_pkg::ADDR_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ffba_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ffba_pkg::t_rsp     o_rsp
);

    import ffba_pkg::*;

    localparam int AW      = ADDR_BITS;
    localparam int CW      = (AW > 32) ? AW : 32;
    localparam int IW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNTW    = $clog2(MAX_ENTRIES + 1);
    localparam int TAG_LO  = 0;
    localparam int FREE_B  = 32;
    localparam int SIZE_LO = 33;
    localparam int OFF_LO  = 33 + AW;
    localparam int EW      = 33 + 2 * AW;

    t_fsm            r_state, n_state;
    logic [AW-1:0]   r_cap, n_cap;
    logic [CNTW-1:0] r_count, n_count;
    logic [AW-1:0]   r_bfree, n_bfree;
    logic [31:0]     r_tag, n_tag;
    logic [CNTW-1:0] r_ptr, n_ptr;
    logic [CNTW-1:0] r_wptr, n_wptr;
    logic [CNTW-1:0] r_idx, n_idx;
    t_req            r_req, n_req;
    logic [AW-1:0]   r_size, n_size;
    logic [AW-1:0]   r_acc_off, n_acc_off;
    logic [AW-1:0]   r_acc_size, n_acc_size;
    logic            r_acc_free, n_acc_free;
    logic [31:0]     r_acc_tag, n_acc_tag;
    t_status         r_st, n_st;
    logic [31:0]     r_goff, n_goff;
    logic [31:0]     r_gtag, n_gtag;
    t_rsp            r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            we;
    logic [IW-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;
    logic [AW-1:0]   rd_off, rd_size;
    logic            rd_free, e_free;
    logic [31:0]     rd_tag;
    logic [CNTW-1:0] ptr_p1, ptr_m1, idx_p1, wptr_p1;
    logic            hit;

    function automatic logic [EW-1:0] pack_entry(logic [AW-1:0] off, logic [AW-1:0] sz,
                                                 logic fr, logic [31:0] tg);
        return {off, sz, fr, tg};
    endfunction

    ffba_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_off  = rdata[OFF_LO +: AW];
    assign rd_size = rdata[SIZE_LO +: AW];
    assign rd_free = rdata[FREE_B];
    assign rd_tag  = rdata[TAG_LO +: 32];
    assign ptr_p1  = r_ptr + CNTW'(1);
    assign ptr_m1  = r_ptr - CNTW'(1);
    assign idx_p1  = r_idx + CNTW'(1);
    assign wptr_p1 = r_wptr + CNTW'(1);
    assign e_free  = rd_free || (r_ptr == r_idx);
    assign hit     = (r_req.req_type == REQ_ALLOC) ? (rd_free && (rd_size >= r_size))
                   : (!rd_free && (CW'(rd_off) == CW'(r_req.block_offset_in)));

    assign o_ready = (r_state == FSM_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_INIT;
            r_cap       <= AW'(RESET_CAPACITY);
            r_count     <= CNTW'(1);
            r_bfree     <= '0;
            r_tag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_count     <= n_count;
            r_bfree     <= n_bfree;
            r_tag       <= n_tag;
            r_out_valid <= n_out_valid;
        end
        r_ptr      <= n_ptr;
        r_wptr     <= n_wptr;
        r_idx      <= n_idx;
        r_req      <= n_req;
        r_size     <= n_size;
        r_acc_off  <= n_acc_off;
        r_acc_size <= n_acc_size;
        r_acc_free <= n_acc_free;
        r_acc_tag  <= n_acc_tag;
        r_st       <= n_st;
        r_goff     <= n_goff;
        r_gtag     <= n_gtag;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_count     = r_count;
        n_bfree     = r_bfree;
        n_tag       = r_tag;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_idx       = r_idx;
        n_req       = r_req;
        n_size      = r_size;
        n_acc_off   = r_acc_off;
        n_acc_size  = r_acc_size;
        n_acc_free  = r_acc_free;
        n_acc_tag   = r_acc_tag;
        n_st        = r_st;
        n_goff      = r_goff;
        n_gtag      = r_gtag;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        we          = 1'b0;
        waddr       = r_ptr[IW-1:0];
        wdata       = pack_entry(r_acc_off, r_acc_size, r_acc_free, r_acc_tag);
        raddr       = r_ptr[IW-1:0];

        case (r_state)
            FSM_INIT: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = pack_entry('0, r_cap, 1'b1, '0);
                n_count = CNTW'(1);
                n_bfree = r_cap;
                n_tag   = '0;
                n_state = FSM_IDLE;
            end
            FSM_IDLE: begin
                if (i_valid) begin
                    n_req  = i_req;
                    n_size = AW'(i_req.req_size);
                    n_goff = '0;
                    n_gtag = '0;
                    n_ptr  = '0;
                    if (AW'(i_req.req_size) == '0) begin
                        n_st    = ST_ZERO;
                        n_state = FSM_DONE;
                    end else begin
                        n_state = FSM_SCAN_RD;
                    end
                end
            end
            FSM_SCAN_RD: begin
                n_state = FSM_SCAN_EX;
            end
            FSM_SCAN_EX: begin
                if (hit) begin
                    n_idx      = r_ptr;
                    n_acc_off  = rd_off;
                    n_acc_size = rd_size;
                    if (r_req.req_type == REQ_FREE) begin
                        n_bfree = r_bfree + rd_size;
                        n_st    = ST_OK;
                        n_ptr   = '0;
                        n_wptr  = '0;
                        n_state = FSM_MERGE_RD;
                    end else if (rd_size == r_size) begin
                        n_state = FSM_GRANT_WR;
                    end else if (r_count == CNTW'(MAX_ENTRIES)) begin
                        n_st    = ST_FULL;
                        n_state = FSM_DONE;
                    end else if (r_count == ptr_p1) begin
                        n_state = FSM_SPLIT_WR;
                    end else begin
                        n_ptr   = r_count;
                        n_state = FSM_SHIFT_RD;
                    end
                end else if (ptr_p1 == r_count) begin
                    n_st    = (r_req.req_type == REQ_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
                    n_state = FSM_DONE;
                end else begin
                    n_ptr   = ptr_p1;
                    n_state = FSM_SCAN_RD;
                end
            end
            FSM_SHIFT_RD: begin
                raddr   = ptr_m1[IW-1:0];
                n_state = FSM_SHIFT_EX;
            end
            FSM_SHIFT_EX: begin
                we    = 1'b1;
                waddr = r_ptr[IW-1:0];
                wdata = rdata;
                if (ptr_m1 == idx_p1) begin
                    n_state = FSM_SPLIT_WR;
                end else begin
                    n_ptr   = ptr_m1;
                    n_state = FSM_SHIFT_RD;
                end
            end
            FSM_SPLIT_WR: begin
                we      = 1'b1;
                waddr   = idx_p1[IW-1:0];
                wdata   = pack_entry(r_acc_off + r_size, r_acc_size - r_size, 1'b1, '0);
                n_count = r_count + CNTW'(1);
                n_state = FSM_GRANT_WR;
            end
            FSM_GRANT_WR: begin
                we      = 1'b1;
                waddr   = r_idx[IW-1:0];
                wdata   = pack_entry(r_acc_off, r_size, 1'b0, r_tag);
                n_st    = ST_OK;
                n_goff  = 32'(r_acc_off);
                n_gtag  = r_tag;
                n_tag   = r_tag + 32'd1;
                n_bfree = r_bfree - r_size;
                n_state = FSM_DONE;
            end
            FSM_MERGE_RD: begin
                n_state = FSM_MERGE_EX;
            end
            FSM_MERGE_EX: begin
                if (r_ptr == '0) begin
                    n_acc_off  = rd_off;
                    n_acc_size = rd_size;
                    n_acc_free = e_free;
                    n_acc_tag  = rd_tag;
                end else if (r_acc_free && e_free) begin
                    n_acc_size = r_acc_size + rd_size;
                end else begin
                    we         = 1'b1;
                    waddr      = r_wptr[IW-1:0];
                    n_wptr     = wptr_p1;
                    n_acc_off  = rd_off;
                    n_acc_size = rd_size;
                    n_acc_free = e_free;
                    n_acc_tag  = rd_tag;
                end
                if (ptr_p1 == r_count) begin
                    n_state = FSM_MERGE_WR;
                end else begin
                    n_ptr   = ptr_p1;
                    n_state = FSM_MERGE_RD;
                end
            end
            FSM_MERGE_WR: begin
                we      = 1'b1;
                waddr   = r_wptr[IW-1:0];
                n_count = wptr_p1;
                n_state = FSM_DONE;
            end
            FSM_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out.status         = r_st;
                    n_out.granted_offset = r_goff;
                    n_out.granted_tag    = r_gtag;
                    n_out.free_total     = 32'(r_bfree);
                    n_out_valid          = 1'b1;
                    n_state              = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_INIT;
            end
        endcase

        if (i_cfg_we) begin
            n_cap   = AW'(i_cfg_data);
            n_state = FSM_INIT;
        end
    end

endmodule

`default_nettype wire
